>>> sv/nrgp_pkg.sv
package nrgp_pkg;

  localparam int MAX_FIELDS_DEF = 30;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_W     = 8'h57;

  localparam logic [2:0] FRAC_STOP   = 3'd7;
  localparam logic [7:0] LAT_DEG_MAX = 8'd90;
  localparam logic [7:0] LON_DEG_MAX = 8'd180;
  localparam logic [31:0] E7         = 32'd10000000;
  // ceil(2^29 / 3): exact quotient by 3 for any dividend below 2^29
  localparam logic [28:0] DIV3_MUL   = 29'd178956971;

  typedef enum logic [3:0] {
    KIND_NONE = 4'b0001,
    KIND_RMC  = 4'b0010,
    KIND_GSV  = 4'b0100,
    KIND_OPEN = 4'b1000
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic        tvalid;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [12:0] cs;
    logic        fix;
    logic [6:0]  lat_deg;
    logic [23:0] lat_min;
    logic        lat_s;
    logic [7:0]  lon_deg;
    logic [23:0] lon_min;
    logic        lon_w;
    logic [18:0] date;
    logic [6:0]  sats;
  } snap_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  fd;
  } acc_t;

  function automatic logic [7:0] rmc_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd1:    r = 8'h47;
      3'd2:    r = 8'h50;
      3'd3:    r = 8'h52;
      3'd4:    r = 8'h4D;
      3'd5:    r = 8'h43;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gsv_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd1:    r = 8'h47;
      3'd2:    r = 8'h50;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h53;
      3'd5:    r = 8'h56;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Push one decimal digit into a 7-bit slot, saturate at 99.
  function automatic logic [31:0] slot_push(input logic [31:0] acc, input logic [1:0] k,
                                            input logic [3:0] dig);
    logic [31:0] a;
    logic [6:0]  v;
    logic [10:0] nv;
    a = acc;
    case (k)
      2'd0:    v = a[6:0];
      2'd1:    v = a[13:7];
      2'd2:    v = a[20:14];
      default: v = a[27:21];
    endcase
    nv = 11'(v) * 11'd10 + 11'(dig);
    if (nv > 11'd99) nv = 11'd99;
    case (k)
      2'd0:    a[6:0]   = nv[6:0];
      2'd1:    a[13:7]  = nv[6:0];
      2'd2:    a[20:14] = nv[6:0];
      default: a[27:21] = nv[6:0];
    endcase
    return a;
  endfunction

  // Bring minutes to units of 1e-5 minute.
  function automatic logic [23:0] min_scale(input logic [23:0] m, input logic [2:0] fd);
    logic [47:0] r;
    case (fd)
      3'd0, 3'd1: r = 48'(m) * 48'd100000;
      3'd2:       r = 48'(m) * 48'd10000;
      3'd3:       r = 48'(m) * 48'd1000;
      3'd4:       r = 48'(m) * 48'd100;
      3'd5:       r = 48'(m) * 48'd10;
      default:    r = 48'(m);
    endcase
    return r[23:0];
  endfunction

  function automatic acc_t feed_coord(input acc_t s, input logic [7:0] c, input logic [3:0] p,
                                      input logic [3:0] degw, input logic [7:0] dmax);
    acc_t        r;
    logic        dig_ok;
    logic [11:0] d;
    logic [27:0] m;
    r = s;
    dig_ok = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (p < degw + 4'd8) begin
      if (p == degw) r.fd = 3'd0;
      if (r.fd != FRAC_STOP) begin
        if (p < degw) begin
          if (dig_ok) begin
            d = 12'(r.acc[31:24]) * 12'd10 + 12'(c[3:0]);
            if (d > 12'(dmax)) d = 12'(dmax);
            r.acc[31:24] = d[7:0];
          end else begin
            r.fd = FRAC_STOP;
          end
        end else begin
          m = 28'(r.acc[23:0]);
          if (dig_ok) begin
            if (r.fd == 3'd0) begin
              m = m * 28'd10 + 28'(c[3:0]);
              if (m > 28'd99) m = 28'd99;
            end else if (r.fd < 3'd6) begin
              m = m * 28'd10 + 28'(c[3:0]);
              r.fd = r.fd + 3'd1;
            end
            r.acc[23:0] = m[23:0];
          end else if (c == CHAR_DOT && r.fd == 3'd0) begin
            r.fd = 3'd1;
          end else begin
            r.acc[23:0] = min_scale(r.acc[23:0], r.fd);
            r.fd = FRAC_STOP;
          end
        end
      end
    end
    return r;
  endfunction

  // degrees*1e7 + round(minutes*1e7/60), saturated at the degree limit
  function automatic logic [31:0] coord_e7(input logic [7:0] deg, input logic [23:0] mins,
                                           input logic [7:0] dmax);
    logic [26:0] x;
    logic [55:0] prod;
    logic [31:0] v;
    logic [31:0] lim;
    x = 27'(mins) * 27'd5 + 27'd1;
    prod = 56'(x) * 56'(DIV3_MUL);
    v = 32'(deg) * E7 + 32'(prod[55:29]);
    lim = 32'(dmax) * E7;
    if (v > lim) v = lim;
    return v;
  endfunction

endpackage

>>> sv/nrgp_step.sv
module nrgp_step import nrgp_pkg::*; #(
  parameter int MaxFields = MAX_FIELDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  output logic       snap_valid_o,
  output snap_t      snap_o
);

  kind_e       kind_q, kind_d;
  logic [2:0]  cil_q, cil_d;
  logic [4:0]  fidx_q, fidx_d;
  logic [3:0]  cif_q, cif_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  fd_q, fd_d;
  logic        tv_q, tv_d;
  logic [4:0]  hh_q, hh_d;
  logic [5:0]  mm_q, mm_d;
  logic [12:0] cs_q, cs_d;
  logic        fix_q, fix_d;
  logic [6:0]  latd_q, latd_d;
  logic [23:0] latm_q, latm_d;
  logic        lats_q, lats_d;
  logic [7:0]  lond_q, lond_d;
  logic [23:0] lonm_q, lonm_d;
  logic        lonw_q, lonw_d;
  logic [18:0] date_q, date_d;
  logic [6:0]  sats_q, sats_d;
  logic        snap_valid_q;
  snap_t       snap_q, snap_d;

  logic        known, dig_ok, fidx_ok, emit, do_accept, do_commit, do_feed;
  logic [7:0]  c;
  logic [3:0]  dig;
  logic [9:0]  f10;
  logic [13:0] cs14;
  logic [6:0]  ch_h, ch_m, ch_d, ch_mo;
  logic [18:0] date_v;
  logic [23:0] cmin;
  logic [10:0] sv;
  acc_t        fs;

  assign c       = byte_i;
  assign dig     = c[3:0];
  assign dig_ok  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign known   = (kind_q == KIND_RMC) || (kind_q == KIND_GSV);
  assign fidx_ok = ({1'b0, fidx_q} < 6'(MaxFields));

  // commit candidates from the field just closed
  always_comb begin
    ch_h = (acc_q[6:0] > 7'd23) ? 7'd23 : acc_q[6:0];
    ch_m = (acc_q[13:7] > 7'd59) ? 7'd59 : acc_q[13:7];
    if (fd_q == 3'd2)     f10 = 10'(acc_q[27:21]) * 10'd10;
    else if (fd_q < 3'd2) f10 = 10'd0;
    else                  f10 = 10'(acc_q[27:21]);
    cs14 = 14'(acc_q[20:14]) * 14'd100 + 14'(f10);
    if (cs14 > 14'd5999) cs14 = 14'd5999;
    ch_d  = (acc_q[6:0] > 7'd31) ? 7'd31 : acc_q[6:0];
    ch_mo = (acc_q[13:7] > 7'd12) ? 7'd12 : acc_q[13:7];
    date_v = 19'(ch_d) * 19'd10000 + 19'(ch_mo) * 19'd100 + 19'(acc_q[20:14]);
    cmin = (fd_q != FRAC_STOP) ? min_scale(acc_q[23:0], fd_q) : acc_q[23:0];
  end

  always_comb begin
    kind_d = kind_q; cil_d = cil_q; fidx_d = fidx_q; cif_d = cif_q;
    acc_d = acc_q; fd_d = fd_q;
    tv_d = tv_q; hh_d = hh_q; mm_d = mm_q; cs_d = cs_q; fix_d = fix_q;
    latd_d = latd_q; latm_d = latm_q; lats_d = lats_q;
    lond_d = lond_q; lonm_d = lonm_q; lonw_d = lonw_q;
    date_d = date_q; sats_d = sats_q;
    emit = 1'b0; do_accept = 1'b0; do_commit = 1'b0; do_feed = 1'b0;
    fs = '{acc: acc_q, fd: fd_q};
    sv = '0;

    if (en_i && c != CHAR_CR) begin
      if (c == CHAR_LF) begin
        if (known && cil_q >= 3'd6) begin
          emit = 1'b1;
          if (cil_q == 3'd6) do_accept = 1'b1;
          else               do_commit = 1'b1;
        end
        kind_d = KIND_OPEN; cil_d = '0; fidx_d = '0; cif_d = '0; acc_d = '0; fd_d = '0;
      end else begin
        if (cil_q < 3'd7) cil_d = cil_q + 3'd1;
        if (cil_q == 3'd0) begin
          if (c == CHAR_COMMA) kind_d = KIND_NONE;
        end else if (cil_q <= 3'd5) begin
          if (((kind_q == KIND_RMC) || (kind_q == KIND_OPEN)) && c == rmc_char(cil_q)) begin
            if (((kind_q == KIND_GSV) || (kind_q == KIND_OPEN)) && c == gsv_char(cil_q))
              kind_d = KIND_OPEN;
            else
              kind_d = KIND_RMC;
          end else if (((kind_q == KIND_GSV) || (kind_q == KIND_OPEN)) &&
                       c == gsv_char(cil_q)) begin
            kind_d = KIND_GSV;
          end else begin
            kind_d = KIND_NONE;
          end
        end else if (cil_q == 3'd6) begin
          if (known && c == CHAR_COMMA) begin
            do_accept = 1'b1;
            fidx_d = 5'd1; cif_d = '0; fd_d = '0; acc_d = '0;
          end else begin
            kind_d = KIND_NONE;
          end
        end else if (known) begin
          if (c == CHAR_COMMA) begin
            do_commit = 1'b1;
            if (fidx_q < 5'd31) fidx_d = fidx_q + 5'd1;
            cif_d = '0; fd_d = '0; acc_d = '0;
          end else begin
            do_feed = fidx_ok;
            if (cif_q < 4'd15) cif_d = cif_q + 4'd1;
          end
        end
      end
    end

    // feed one character into the open field
    if (do_feed) begin
      if (kind_q == KIND_RMC) begin
        case (fidx_q)
          5'd1: begin
            if (cif_q < 4'd2) begin
              if (dig_ok) fs.acc = slot_push(acc_q, 2'd0, dig);
            end else if (cif_q < 4'd4) begin
              if (dig_ok) fs.acc = slot_push(acc_q, 2'd1, dig);
            end else if (cif_q < 4'd9) begin
              if (c == CHAR_DOT && fd_q == 3'd0) begin
                fs.fd = 3'd1;
              end else if (dig_ok) begin
                if (fd_q == 3'd0) begin
                  fs.acc = slot_push(acc_q, 2'd2, dig);
                end else if (fd_q < 3'd3) begin
                  fs.acc = slot_push(acc_q, 2'd3, dig);
                  fs.fd = fd_q + 3'd1;
                end
              end
            end
          end
          5'd2: if (cif_q == 4'd0) fs.acc = {31'd0, c == CHAR_A};
          5'd4: if (cif_q == 4'd0) fs.acc = {31'd0, c == CHAR_S};
          5'd6: if (cif_q == 4'd0) fs.acc = {31'd0, c == CHAR_W};
          5'd3: fs = feed_coord(fs, c, cif_q, 4'd2, LAT_DEG_MAX);
          5'd5: fs = feed_coord(fs, c, cif_q, 4'd3, LON_DEG_MAX);
          5'd9: if (dig_ok && cif_q < 4'd6) fs.acc = slot_push(acc_q, cif_q[2:1], dig);
          default: ;
        endcase
      end else if (fidx_q == 5'd3) begin
        // satellites: signed leading number, negative reads as zero
        if (fd_q != FRAC_STOP && !(cif_q == 4'd0 && c == CHAR_PLUS)) begin
          if (dig_ok) begin
            sv = 11'(acc_q[6:0]) * 11'd10 + 11'(dig);
            if (sv > 11'd99) sv = 11'd99;
            fs.acc = 32'(sv);
          end else begin
            if (cif_q == 4'd0 && c == CHAR_MINUS) fs.acc = '0;
            fs.fd = FRAC_STOP;
          end
        end
      end
      acc_d = fs.acc;
      fd_d  = fs.fd;
    end

    if (do_accept) begin
      if (kind_q == KIND_RMC) begin
        tv_d = 1'b0; hh_d = '0; mm_d = '0; cs_d = '0; fix_d = 1'b0;
      end else begin
        sats_d = '0;
      end
    end

    if (do_commit && fidx_ok && cif_q != 4'd0) begin
      if (kind_q == KIND_RMC) begin
        case (fidx_q)
          5'd1: begin
            tv_d = 1'b1; hh_d = ch_h[4:0]; mm_d = ch_m[5:0]; cs_d = cs14[12:0];
          end
          5'd2: fix_d = (cif_q == 4'd1) && (acc_q == 32'd1);
          5'd3: begin latd_d = acc_q[30:24]; latm_d = cmin; end
          5'd4: lats_d = (acc_q == 32'd1);
          5'd5: begin lond_d = acc_q[31:24]; lonm_d = cmin; end
          5'd6: lonw_d = (acc_q == 32'd1);
          5'd9: date_d = date_v;
          default: ;
        endcase
      end else if (fidx_q == 5'd3) begin
        sats_d = acc_q[6:0];
      end
    end

    snap_d.kind    = (kind_q == KIND_GSV);
    snap_d.tvalid  = tv_d;
    snap_d.hours   = hh_d;
    snap_d.minutes = mm_d;
    snap_d.cs      = cs_d;
    snap_d.fix     = fix_d;
    snap_d.lat_deg = latd_d;
    snap_d.lat_min = latm_d;
    snap_d.lat_s   = lats_d;
    snap_d.lon_deg = lond_d;
    snap_d.lon_min = lonm_d;
    snap_d.lon_w   = lonw_d;
    snap_d.date    = date_d;
    snap_d.sats    = sats_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_OPEN; cil_q <= '0; fidx_q <= '0; cif_q <= '0; acc_q <= '0; fd_q <= '0;
      tv_q <= 1'b0; hh_q <= '0; mm_q <= '0; cs_q <= '0; fix_q <= 1'b0;
      latd_q <= '0; latm_q <= '0; lats_q <= 1'b0;
      lond_q <= '0; lonm_q <= '0; lonw_q <= 1'b0;
      date_q <= '0; sats_q <= '0;
      snap_valid_q <= 1'b0;
    end else if (adv_i) begin
      kind_q <= kind_d; cil_q <= cil_d; fidx_q <= fidx_d; cif_q <= cif_d;
      acc_q <= acc_d; fd_q <= fd_d;
      tv_q <= tv_d; hh_q <= hh_d; mm_q <= mm_d; cs_q <= cs_d; fix_q <= fix_d;
      latd_q <= latd_d; latm_q <= latm_d; lats_q <= lats_d;
      lond_q <= lond_d; lonm_q <= lonm_d; lonw_q <= lonw_d;
      date_q <= date_d; sats_q <= sats_d;
      snap_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && emit) snap_q <= snap_d;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

>>> sv/nrgp_conv.sv
module nrgp_conv import nrgp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        snap_valid_i,
  input  snap_t       snap_i,
  output logic        out_valid_o,
  output snap_t       snap_o,
  output logic [29:0] lat_e7_o,
  output logic [30:0] lon_e7_o
);

  logic        out_valid_q;
  snap_t       snap_q;
  logic [31:0] lat_d, lon_d;
  logic [29:0] lat_q;
  logic [30:0] lon_q;

  assign lat_d = coord_e7({1'b0, snap_i.lat_deg}, snap_i.lat_min, LAT_DEG_MAX);
  assign lon_d = coord_e7(snap_i.lon_deg, snap_i.lon_min, LON_DEG_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && snap_valid_i) begin
      snap_q <= snap_i;
      lat_q  <= lat_d[29:0];
      lon_q  <= lon_d[30:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign snap_o      = snap_q;
  assign lat_e7_o    = lat_q;
  assign lon_e7_o    = lon_q;

endmodule

>>> sv/nmea_rmc_gsv_sentence_parser.sv
// RMC/GSV text line parser.
// Input channel: one received character per beat (rx_byte_i), valid/ready.
// Output channel: one beat per handled line, carrying every held value.
// Carriage returns are dropped; a newline closes the line and, for a GPRMC or
// GPGSV line, produces a result beat. Other lines produce nothing.
// Throughput: one character per cycle while the output is not stalled; a three-register pipeline
// (input byte, parser state with result snapshot, coordinate conversion).
// A newline's result beat passes the byte, snapshot and conversion registers in turn.
// Stall: the whole pipeline advances only when the output register is empty
// or being taken, and in_ready_o follows that same condition; nothing is lost.
// Reset: the parser waits at the start of a line, time is invalid, fix,
// coordinates, hemispheres, date and satellite count are zero.
module nmea_rmc_gsv_sentence_parser import nrgp_pkg::*; #(
  parameter int MaxFields = MAX_FIELDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        sentence_kind_o,
  output logic        time_valid_o,
  output logic [4:0]  utc_hours_o,
  output logic [5:0]  utc_minutes_o,
  output logic [12:0] utc_centiseconds_o,
  output logic        fix_valid_o,
  output logic [29:0] lat_e7_o,
  output logic        lat_south_o,
  output logic [30:0] lon_e7_o,
  output logic        lon_west_o,
  output logic [18:0] date_ddmmyy_o,
  output logic [6:0]  sats_in_view_o
);

  logic       adv;
  logic       byte_valid_q;
  logic [7:0] byte_q;
  logic       snap_valid;
  snap_t      snap, snap_out;

  // advance every stage together when the output slot frees up
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (adv) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) byte_q <= rx_byte_i;
  end

  nrgp_step #(.MaxFields(MaxFields)) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .en_i         (byte_valid_q),
    .byte_i       (byte_q),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  nrgp_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .out_valid_o  (out_valid_o),
    .snap_o       (snap_out),
    .lat_e7_o     (lat_e7_o),
    .lon_e7_o     (lon_e7_o)
  );

  assign sentence_kind_o    = snap_out.kind;
  assign time_valid_o       = snap_out.tvalid;
  assign utc_hours_o        = snap_out.hours;
  assign utc_minutes_o      = snap_out.minutes;
  assign utc_centiseconds_o = snap_out.cs;
  assign fix_valid_o        = snap_out.fix;
  assign lat_south_o        = snap_out.lat_s;
  assign lon_west_o         = snap_out.lon_w;
  assign date_ddmmyy_o      = snap_out.date;
  assign sats_in_view_o     = snap_out.sats;

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lat_e7_o <= 30'd900000000)
    else $error("latitude beyond 90 degrees");

  a_lon_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lon_e7_o <= 31'd1800000000)
    else $error("longitude beyond 180 degrees");

  a_time_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !time_valid_o) |->
      (utc_hours_o == 5'd0 && utc_minutes_o == 6'd0 && utc_centiseconds_o == 13'd0))
    else $error("invalid time carries nonzero value");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sats_in_view_o <= 7'd99 && utc_hours_o <= 5'd23))
    else $error("satellite count or hours out of range");

endmodule

>>> test/nmea_rmc_gsv_sentence_parser_test.sv
`timescale 1ns / 100ps

module nmea_rmc_gsv_sentence_parser_test;
  import nrgp_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int RandBytes  = 1050;

  typedef struct packed {
    logic        kind;
    logic        tvalid;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [12:0] cs;
    logic        fix;
    logic [29:0] lat;
    logic        lat_s;
    logic [30:0] lon;
    logic        lon_w;
    logic [18:0] date;
    logic [6:0]  sats;
  } fix_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        sentence_kind_o;
  logic        time_valid_o;
  logic [4:0]  utc_hours_o;
  logic [5:0]  utc_minutes_o;
  logic [12:0] utc_centiseconds_o;
  logic        fix_valid_o;
  logic [29:0] lat_e7_o;
  logic        lat_south_o;
  logic [30:0] lon_e7_o;
  logic        lon_west_o;
  logic [18:0] date_ddmmyy_o;
  logic [6:0]  sats_in_view_o;

  always #2 clk_i = ~clk_i;

  nmea_rmc_gsv_sentence_parser dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rx_byte_i, .out_valid_o, .out_ready_i,
    .sentence_kind_o, .time_valid_o, .utc_hours_o, .utc_minutes_o, .utc_centiseconds_o,
    .fix_valid_o, .lat_e7_o, .lat_south_o, .lon_e7_o, .lon_west_o, .date_ddmmyy_o,
    .sats_in_view_o
  );

  // ---------------------------------------------------------------------------
  // Line parser mirror: header match, field split, per-field gathering
  // ---------------------------------------------------------------------------
  kind_e       line_kind;
  logic [2:0]  line_pos;
  logic [4:0]  field_no;
  logic [3:0]  field_pos;
  logic [31:0] gather;
  logic [2:0]  frac_cnt;

  logic        hold_tvalid;
  logic [4:0]  hold_hours;
  logic [5:0]  hold_minutes;
  logic [12:0] hold_cs;
  logic        hold_fix;
  logic [31:0] hold_lat;
  logic        hold_south;
  logic [31:0] hold_lon;
  logic        hold_west;
  logic [18:0] hold_date;
  logic [6:0]  hold_sats;

  fix_report_t fix_reports_due[$];
  int          mismatches;
  int          reports_seen;
  int          lines_sent;
  int          bytes_sent;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic int unsigned slot_of(input int sh);
    return (gather >> sh) & 32'h7F;
  endfunction

  function automatic void slot_add(input int sh, input logic [7:0] c);
    int unsigned v;
    v = slot_of(sh) * 10 + (c - CHAR_ZERO);
    if (v > 99) v = 99;
    gather = (gather & ~(32'h7F << sh)) | (v << sh);
  endfunction

  function automatic void clear_field();
    field_pos = '0;
    frac_cnt  = '0;
    gather    = '0;
  endfunction

  function automatic void restart_line();
    line_kind = KIND_OPEN;
    line_pos  = '0;
    field_no  = '0;
    clear_field();
  endfunction

  // Opening a handled line drops the per-line values of its kind.
  function automatic void open_line();
    if (line_kind == KIND_RMC) begin
      hold_tvalid  = 1'b0;
      hold_hours   = '0;
      hold_minutes = '0;
      hold_cs      = '0;
      hold_fix     = 1'b0;
    end else begin
      hold_sats = '0;
    end
  endfunction

  // Bring gathered minutes to units of 1e-5 minute.
  function automatic void scale_minutes();
    int unsigned m;
    int          n;
    m = gather & 32'hFFFFFF;
    n = (frac_cnt == 0) ? 0 : frac_cnt - 1;
    for (; n < 5; n++) m = m * 10;
    gather = (gather & 32'hFF000000) | (m & 32'hFFFFFF);
  endfunction

  function automatic int unsigned coord_units(input int unsigned deg_max);
    int unsigned m;
    int unsigned v;
    if (frac_cnt != FRAC_STOP) scale_minutes();
    m = gather & 32'hFFFFFF;
    v = (gather >> 24) * 10000000 + (m * 5 + 1) / 3;
    if (v > deg_max * 10000000) v = deg_max * 10000000;
    return v;
  endfunction

  function automatic void gather_time(input logic [7:0] c, input int p);
    if (p < 2) begin
      if (is_digit(c)) slot_add(0, c);
    end else if (p < 4) begin
      if (is_digit(c)) slot_add(7, c);
    end else if (p < 9) begin
      if (c == CHAR_DOT && frac_cnt == 0) frac_cnt = 3'd1;
      else if (is_digit(c)) begin
        if (frac_cnt == 0) slot_add(14, c);
        else if (frac_cnt < 3) begin
          slot_add(21, c);
          frac_cnt++;
        end
      end
    end
  endfunction

  function automatic void gather_coord(input logic [7:0] c, input int p, input int deg_w,
                                       input int unsigned deg_max);
    int unsigned d;
    int unsigned m;
    if (p >= deg_w + 8) return;
    if (p == deg_w) frac_cnt = '0;
    if (frac_cnt == FRAC_STOP) return;
    if (p < deg_w) begin
      if (is_digit(c)) begin
        d = (gather >> 24) * 10 + (c - CHAR_ZERO);
        if (d > deg_max) d = deg_max;
        gather = (gather & 32'hFFFFFF) | (d << 24);
      end else frac_cnt = FRAC_STOP;
      return;
    end
    m = gather & 32'hFFFFFF;
    if (is_digit(c)) begin
      if (frac_cnt == 0) begin
        m = m * 10 + (c - CHAR_ZERO);
        if (m > 99) m = 99;
      end else if (frac_cnt < 6) begin
        m = m * 10 + (c - CHAR_ZERO);
        frac_cnt++;
      end
      gather = (gather & 32'hFF000000) | m;
    end else if (c == CHAR_DOT && frac_cnt == 0) begin
      frac_cnt = 3'd1;
    end else begin
      scale_minutes();
      frac_cnt = FRAC_STOP;
    end
  endfunction

  function automatic void gather_sats(input logic [7:0] c, input int p);
    if (frac_cnt == FRAC_STOP) return;
    if (p == 0 && c == CHAR_PLUS) return;
    if (is_digit(c)) begin
      gather = gather * 10 + (c - CHAR_ZERO);
      if (gather > 99) gather = 99;
    end else begin
      if (p == 0 && c == CHAR_MINUS) gather = 0;
      frac_cnt = FRAC_STOP;
    end
  endfunction

  function automatic void gather_char(input logic [7:0] c);
    logic [7:0] flag_char;
    int         p;
    p = field_pos;
    if (line_kind == KIND_RMC) begin
      case (field_no)
        5'd1: gather_time(c, p);
        5'd2, 5'd4, 5'd6: begin
          flag_char = (field_no == 2) ? CHAR_A : (field_no == 4) ? CHAR_S : CHAR_W;
          if (p == 0) gather = (c == flag_char) ? 1 : 0;
        end
        5'd3: gather_coord(c, p, 2, LAT_DEG_MAX);
        5'd5: gather_coord(c, p, 3, LON_DEG_MAX);
        5'd9: if (is_digit(c) && p < 6) slot_add((p / 2) * 7, c);
        default: ;
      endcase
    end else if (field_no == 3) begin
      gather_sats(c, p);
    end
  endfunction

  function automatic void close_field();
    int unsigned h, m, f, cs, d;
    if (field_no >= MAX_FIELDS_DEF || field_pos == 0) return;
    if (line_kind == KIND_RMC) begin
      case (field_no)
        5'd1: begin
          h = slot_of(0);
          m = slot_of(7);
          f = slot_of(21);
          if (frac_cnt == 2) f = f * 10;
          else if (frac_cnt < 2) f = 0;
          cs = slot_of(14) * 100 + f;
          hold_tvalid  = 1'b1;
          hold_hours   = 5'((h > 23) ? 23 : h);
          hold_minutes = 6'((m > 59) ? 59 : m);
          hold_cs      = 13'((cs > 5999) ? 5999 : cs);
        end
        5'd2: hold_fix = (field_pos == 1 && gather == 1);
        5'd3: hold_lat = coord_units(LAT_DEG_MAX);
        5'd4: hold_south = (gather == 1);
        5'd5: hold_lon = coord_units(LON_DEG_MAX);
        5'd6: hold_west = (gather == 1);
        5'd9: begin
          d = slot_of(0);
          m = slot_of(7);
          if (d > 31) d = 31;
          if (m > 12) m = 12;
          hold_date = 19'(d * 10000 + m * 100 + slot_of(14));
        end
        default: ;
      endcase
    end else if (field_no == 3) begin
      hold_sats = gather[6:0];
    end
  endfunction

  function automatic void clear_held();
    restart_line();
    hold_tvalid = 1'b0; hold_hours = '0; hold_minutes = '0; hold_cs = '0;
    hold_fix = 1'b0; hold_lat = '0; hold_south = 1'b0; hold_lon = '0; hold_west = 1'b0;
    hold_date = '0; hold_sats = '0;
  endfunction

  // Advance the mirror by one accepted byte; return 1 when a report is due.
  function automatic bit parse_byte(input logic [7:0] c, output fix_report_t r);
    string rmc_tag;
    string gsv_tag;
    int    p;
    bit    known, rm, gm, hit;
    rmc_tag = "GPRMC";
    gsv_tag = "GPGSV";
    p = line_pos;
    known = (line_kind == KIND_RMC) || (line_kind == KIND_GSV);
    r = '0;
    hit = 1'b0;
    if (c == CHAR_CR) return 1'b0;
    if (c == CHAR_LF) begin
      if (known && p >= 6) begin
        if (p == 6) open_line();
        else close_field();
        r = '{kind: line_kind == KIND_GSV, tvalid: hold_tvalid, hours: hold_hours,
              minutes: hold_minutes, cs: hold_cs, fix: hold_fix, lat: hold_lat[29:0],
              lat_s: hold_south, lon: hold_lon[30:0], lon_w: hold_west, date: hold_date,
              sats: hold_sats};
        hit = 1'b1;
      end
      restart_line();
      return hit;
    end
    if (p < 7) line_pos = 3'(p + 1);
    if (p == 0) begin
      if (c == CHAR_COMMA) line_kind = KIND_NONE;
    end else if (p <= 5) begin
      rm = (line_kind == KIND_RMC || line_kind == KIND_OPEN) && c == rmc_tag[p-1];
      gm = (line_kind == KIND_GSV || line_kind == KIND_OPEN) && c == gsv_tag[p-1];
      line_kind = (rm && gm) ? KIND_OPEN : rm ? KIND_RMC : gm ? KIND_GSV : KIND_NONE;
    end else if (p == 6) begin
      if (known && c == CHAR_COMMA) begin
        open_line();
        field_no = 5'd1;
        clear_field();
      end else line_kind = KIND_NONE;
    end else if (known) begin
      if (c == CHAR_COMMA) begin
        close_field();
        if (field_no < 31) field_no++;
        clear_field();
      end else begin
        if (field_no < MAX_FIELDS_DEF) gather_char(c);
        if (field_pos < 15) field_pos++;
      end
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one byte per beat, random gaps, burst stretches without gaps
  // ---------------------------------------------------------------------------
  bit          burst_mode;
  bit          typed_pending;
  fix_report_t typed_report;

  task automatic send_byte(input logic [7:0] c);
    fix_report_t r;
    int          gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (parse_byte(c, r)) begin
      // Directed rows with a hand-written report override the mirror's one.
      if (typed_pending) begin
        if (r !== typed_report)
          $display("note: mirror disagrees with typed report %p / %p", r, typed_report);
        r = typed_report;
        typed_pending = 1'b0;
      end
      fix_reports_due.push_back(r);
    end
  endtask

  // Send a text line; optionally sprinkle carriage returns.
  task automatic send_text(input string s, input bit sprinkle_cr);
    for (int i = 0; i < s.len(); i++) begin
      if (sprinkle_cr && $urandom_range(0, 29) == 0) send_byte(CHAR_CR);
      send_byte(s[i]);
    end
    lines_sent++;
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random sentence content
  // ---------------------------------------------------------------------------
  function automatic string rnd_text(input int max_len);
    string s;
    int    n;
    int    k;
    s = "";
    n = $urandom_range(0, max_len);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 14) s = {s, string'(8'(CHAR_ZERO + $urandom_range(0, 9)))};
      else if (k < 16) s = {s, "."};
      else if (k == 16) s = {s, "-"};
      else if (k == 17) s = {s, "+"};
      else begin
        k = $urandom_range(33, 126);
        if (k == CHAR_COMMA) k = CHAR_A;
        s = {s, string'(8'(k))};
      end
    end
    return s;
  endfunction

  function automatic string pick(input string a, input string b, input string c);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return rnd_text(3);
    endcase
  endfunction

  function automatic string make_rmc();
    string s, t, lat, lon, dt;
    int    extra;
    if ($urandom_range(0, 3) == 0) t = rnd_text(11);
    else t = $sformatf("%02d%02d%02d.%0d", $urandom_range(0, 29), $urandom_range(0, 69),
                       $urandom_range(0, 69), $urandom_range(0, 999));
    if ($urandom_range(0, 3) == 0) lat = rnd_text(12);
    else lat = $sformatf("%02d%02d.%05d", $urandom_range(0, 95), $urandom_range(0, 99),
                         $urandom_range(0, 99999));
    if ($urandom_range(0, 3) == 0) lon = rnd_text(13);
    else lon = $sformatf("%03d%02d.%04d", $urandom_range(0, 185), $urandom_range(0, 99),
                         $urandom_range(0, 9999));
    if ($urandom_range(0, 3) == 0) dt = rnd_text(8);
    else dt = $sformatf("%02d%02d%02d", $urandom_range(0, 35), $urandom_range(0, 15),
                        $urandom_range(0, 99));
    if ($urandom_range(0, 6) == 0) lat = "";
    if ($urandom_range(0, 6) == 0) lon = "";
    s = {"$GPRMC,", t, ",", pick("A", "V", ""), ",", lat, ",", pick("N", "S", ""), ",", lon,
         ",", pick("E", "W", ""), ",", rnd_text(5), ",", rnd_text(5), ",", dt};
    // Mostly a checksum tail; now and then run past the field limit.
    extra = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 26) : $urandom_range(0, 3);
    for (int i = 0; i < extra; i++) s = {s, ",", rnd_text(2)};
    if ($urandom_range(0, 5) == 0) s = s.substr(0, $urandom_range(5, s.len() - 1));
    return {s, "*4F\n"};
  endfunction

  function automatic string make_gsv();
    string s;
    s = {"$GPGSV,", rnd_text(2), ",", rnd_text(2), ",",
         pick($sformatf("%0d", $urandom_range(0, 150)), "-7", "+12")};
    for (int i = $urandom_range(0, 8); i > 0; i--) s = {s, ",", rnd_text(3)};
    if ($urandom_range(0, 7) == 0) s = "$GPGSV,3";
    return {s, "\n"};
  endfunction

  function automatic string make_broken();
    string s;
    s = ($urandom_range(0, 1) == 0) ? make_rmc() : make_gsv();
    case ($urandom_range(0, 3))
      0: s[$urandom_range(1, 5)] = "X";
      1: s[0] = ",";
      2: s = {s.substr(0, $urandom_range(0, 5)), "\n"};
      default: s[6] = "Y";
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off that backs the block up
  // ---------------------------------------------------------------------------
  initial begin
    int  stall;
    int  beats;
    bit  rx_burst;
    beats = 0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 7) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 13);
      if (beats == 25) stall = HoldCycles;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats++;
    end
  end

  // Compare every taken result beat with the oldest expected report.
  always @(posedge clk_i) begin
    fix_report_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{sentence_kind_o, time_valid_o, utc_hours_o, utc_minutes_o, utc_centiseconds_o,
              fix_valid_o, lat_e7_o, lat_south_o, lon_e7_o, lon_west_o, date_ddmmyy_o,
              sats_in_view_o};
      reports_seen++;
      if (fix_reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = fix_reports_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk_i) begin
    int idle;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
    else idle++;
    if (rst_ni && idle >= StallLimit) begin
      $display("watchdog: no beats for %0d cycles", StallLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  string       dir_rows[$];
  fix_report_t dir_want[int];

  initial begin
    int k;
    clear_held();
    // Directed rows: report typed in where it is obvious, mirror elsewhere.
    dir_rows = '{
      "$GPGSV,3,1,12\n",
      "$GPRMC\n",
      "$GPRMC,999999.999,A,9999.99999,S,99999.99999,W,,,999999\n",
      ",GPRMC,1\n",
      "$GPR\n",
      "$GPRMC,1234\n",
      "$GPGSV,,,-5\n",
      "$GPRMCX\n"
    };
    dir_want[0] = '{kind: 1'b1, sats: 7'd12, default: '0};
    dir_want[1] = '{kind: 1'b0, sats: 7'd12, default: '0};
    dir_want[2] = '{kind: 1'b0, tvalid: 1'b1, hours: 5'd23, minutes: 6'd59, cs: 13'd5999,
                    fix: 1'b1, lat: 30'd900000000, lat_s: 1'b1, lon: 31'd1800000000,
                    lon_w: 1'b1, date: 19'd311299, sats: 7'd12};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_mode = 1'b0;
    foreach (dir_rows[i]) begin
      typed_pending = dir_want.exists(i);
      if (typed_pending) typed_report = dir_want[i];
      send_text(dir_rows[i], 1'b0);
    end
    // Odd bytes: NUL, top bit set, stray CR, then close the line.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);

    // Let everything drain before the random part starts.
    drop_valid();
    while (fix_reports_due.size() != 0) @(posedge clk_i);

    while (bytes_sent < RandBytes) begin
      if ($urandom_range(0, 5) == 0) burst_mode = ~burst_mode;
      k = $urandom_range(0, 19);
      if (k < 9) send_text(make_rmc(), 1'b1);
      else if (k < 14) send_text(make_gsv(), 1'b1);
      else if (k < 17) send_text(make_broken(), 1'b1);
      else begin
        for (int i = $urandom_range(1, 12); i > 0; i--) send_byte(8'($urandom_range(0, 255)));
        send_byte(CHAR_LF);
      end
    end
    drop_valid();

    while (fix_reports_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d bytes in %0d lines, %0d result beats checked, %0d mismatches",
             bytes_sent, lines_sent, reports_seen, mismatches);
    $display("lines mixed RMC, GSV, broken headers, field overflow and raw byte noise");
    if (mismatches == 0 && fix_reports_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
